// ===== hdl/flipdot_panel_column_driver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the flip-dot panel column driver
// Shared property forms for the concurrent checks in the driver.
// ----------------------------------------------------------------------------
`ifndef FLIPDOT_PANEL_COLUMN_DRIVER_UNIT_DEFINES_SVH
`define FLIPDOT_PANEL_COLUMN_DRIVER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define FPCD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Flip-dot column driver package
// Operation codes and fixed field widths used by the driver module.
// ----------------------------------------------------------------------------
package fpcd_pkg;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int COL_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int ROW_SEL_W = 4;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_SELECT = 3'd0,
        OP_SHIFT  = 3'd1,
        OP_STROBE = 3'd2,
        OP_BLACK  = 3'd3,
        OP_WHITE  = 3'd4,
        OP_READ   = 3'd5
    } t_op;

endpackage

// ===== hdl/fpcd_bitmap_store.sv =====
// ----------------------------------------------------------------------------
// Bitmap column store
// One column word per entry, one write and one registered read per cycle,
// per-entry valid bits so that unwritten columns read as clear, and a
// bypass for a write landing on the address read in the same cycle.
// ----------------------------------------------------------------------------
module fpcd_bitmap_store #(
    parameter int  COLUMNS = 32,
    parameter int  ROWS    = 16,
    localparam int AW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output logic [ROWS-1:0] o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [ROWS-1:0] i_wr_data
);

    logic [ROWS-1:0]    r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_vld;
    logic [ROWS-1:0]    r_rd_mem;
    logic               r_rd_vld;
    logic               r_byp;
    logic [ROWS-1:0]    r_byp_data;

    // Write the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the array
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_mem <= r_mem[i_rd_addr];
        end
    end

    // Mark written columns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Capture valid flag and same-cycle write bypass alongside the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
            r_byp    <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr_data;
        end
    end

    // Select bypass, stored word or the cleared value
    always_comb begin
        if (r_byp) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_mem;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

// ===== hdl/flipdot_panel_column_driver_unit.sv =====
// ----------------------------------------------------------------------------
// Flip-dot panel column driver
// Byte shift chain, column select, staged and shown bitmaps, dot readback.
// ----------------------------------------------------------------------------
//  channel  | direction | tuser          | tdata (lowest bit up)
//  s_axis   | in        | operation [2:0]| column_index, data_byte, dot_x, dot_y
//  m_axis   | out       | -              | chain_out_byte, dot_black
//
//  One transaction per clock while m_axis_tready stays high; a result passes
//  through the working stage, beside the registered bitmap read, then the result register.
//  Reset is synchronous, active low, and clears chain, column and both
//  bitmaps at once through per-column valid bits.
//  A stalled output holds the result register, then the working stage, then
//  s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "flipdot_panel_column_driver_unit_defines.svh"

module flipdot_panel_column_driver_unit #(
    parameter int ROWS        = 16,
    parameter int COLUMNS     = 32,
    parameter int CHAIN_BYTES = 2,
    parameter int OUTPUT_BYTE = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] operation
    input  logic [fpcd_pkg::OP_W-1:0]      s_axis_tuser,
    // [4:0] column_index, [12:5] data_byte, [17:13] dot_x, [21:18] dot_y
    input  logic [fpcd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] chain_out_byte, [8] dot_black
    output logic [fpcd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import fpcd_pkg::*;

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int XW = (AW > COL_W) ? AW : COL_W;
    localparam int CW = 8 * CHAIN_BYTES;
    localparam int WW = (ROWS > CW) ? ROWS : CW;

    // Input fields
    t_op                  w_op;
    logic [COL_W-1:0]     w_col_in;
    logic [BYTE_W-1:0]    w_data;
    logic [COL_W-1:0]     w_x;
    logic [ROW_SEL_W-1:0] w_y;
    logic                 w_accept;
    logic                 w_s1_adv;

    // Small state
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [BYTE_W-1:0] r_chain [CHAIN_BYTES];
    logic [BYTE_W-1:0] n_chain [CHAIN_BYTES];

    // Decoded selections
    logic [XW-1:0]     w_sel_ext;
    logic [XW-1:0]     w_x_ext;
    logic [AW-1:0]     w_sel_addr;
    logic [AW-1:0]     w_shown_rd_addr;
    logic              w_sel_ok;
    logic              w_dot_ok;
    logic [CW-1:0]     w_flat;
    logic [WW-1:0]     w_flat_ext;
    logic [ROWS-1:0]   w_word;
    logic [BYTE_W-1:0] w_chain_out;

    // Working stage
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic              r_s1_sel_ok;
    logic [AW-1:0]     r_s1_sel_addr;
    logic [ROWS-1:0]   r_s1_word;
    logic [BYTE_W-1:0] r_s1_chain_out;
    logic              r_s1_dot_ok;
    logic [ROW_SEL_W-1:0] r_s1_dot_y;

    // Bitmap ports
    logic [ROWS-1:0] w_staged_rd;
    logic [ROWS-1:0] w_shown_rd;
    logic            w_staged_wr;
    logic            w_shown_wr;
    logic [ROWS-1:0] w_shown_new;
    logic [ROWS-1:0] w_dot_sh;
    logic            w_dot;

    // Result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_chain;
    logic              r_out_dot;

    // Unpack the transaction
    assign w_op     = t_op'(s_axis_tuser);
    assign w_col_in = s_axis_tdata[4:0];
    assign w_data   = s_axis_tdata[12:5];
    assign w_x      = s_axis_tdata[17:13];
    assign w_y      = s_axis_tdata[21:18];

    // Handshake: the working stage drains into the result register
    assign w_s1_adv      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Next column select
    always_comb begin
        n_col = r_col;
        if (w_accept && (w_op == OP_SELECT)) begin
            n_col = w_col_in;
        end
    end

    // Next chain contents: shift on a byte push
    always_comb begin
        for (int i = 0; i < CHAIN_BYTES; i++) begin
            n_chain[i] = r_chain[i];
        end
        if (w_accept && (w_op == OP_SHIFT)) begin
            n_chain[0] = w_data;
            for (int i = 1; i < CHAIN_BYTES; i++) begin
                n_chain[i] = r_chain[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            for (int i = 0; i < CHAIN_BYTES; i++) begin
                r_chain[i] <= '0;
            end
        end else begin
            r_col <= n_col;
            for (int i = 0; i < CHAIN_BYTES; i++) begin
                r_chain[i] <= n_chain[i];
            end
        end
    end

    // Chain byte at the output position after this command
    generate
        if (OUTPUT_BYTE < CHAIN_BYTES) begin : g_out_byte
            assign w_chain_out = n_chain[OUTPUT_BYTE];
        end else begin : g_no_out_byte
            assign w_chain_out = '0;
        end
    endgenerate

    // Low ROWS bits of the chain, zero beyond its end
    always_comb begin
        for (int b = 0; b < CHAIN_BYTES; b++) begin
            w_flat[8*b +: 8] = r_chain[b];
        end
    end
    assign w_flat_ext = WW'(w_flat);
    assign w_word     = w_flat_ext[ROWS-1:0];

    // Column addresses and range checks
    assign w_sel_ext  = XW'(r_col);
    assign w_x_ext    = XW'(w_x);
    assign w_sel_addr = w_sel_ext[AW-1:0];
    assign w_sel_ok   = int'(r_col) < COLUMNS;
    assign w_dot_ok   = (int'(w_x) < COLUMNS) && (int'(w_y) < ROWS);
    assign w_shown_rd_addr = (w_op == OP_READ) ? w_x_ext[AW-1:0] : w_sel_addr;

    // Load the working stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op        <= w_op;
            r_s1_sel_ok    <= w_sel_ok;
            r_s1_sel_addr  <= w_sel_addr;
            r_s1_word      <= w_word;
            r_s1_chain_out <= w_chain_out;
            r_s1_dot_ok    <= w_dot_ok;
            r_s1_dot_y     <= w_y;
        end
    end

    // Bitmap updates when the stage retires
    assign w_staged_wr = w_s1_adv && r_s1_sel_ok && (r_s1_op == OP_STROBE);
    assign w_shown_wr  = w_s1_adv && r_s1_sel_ok &&
                         ((r_s1_op == OP_BLACK) || (r_s1_op == OP_WHITE));

    always_comb begin
        unique case (r_s1_op)
            OP_BLACK: w_shown_new = w_shown_rd | w_staged_rd;
            default:  w_shown_new = w_shown_rd & w_staged_rd;
        endcase
    end

    fpcd_bitmap_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_staged (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_sel_addr),
        .o_rd_data (w_staged_rd),
        .i_wr_en   (w_staged_wr),
        .i_wr_addr (r_s1_sel_addr),
        .i_wr_data (r_s1_word)
    );

    fpcd_bitmap_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_shown (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_shown_rd_addr),
        .o_rd_data (w_shown_rd),
        .i_wr_en   (w_shown_wr),
        .i_wr_addr (r_s1_sel_addr),
        .i_wr_data (w_shown_new)
    );

    // Pick the dot for readback
    assign w_dot_sh = w_shown_rd >> r_s1_dot_y;
    assign w_dot    = (r_s1_op == OP_READ) && r_s1_dot_ok && w_dot_sh[0];

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_chain <= r_s1_chain_out;
            r_out_dot   <= w_dot;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_dot, r_out_chain};

    // Checks
    `FPCD_ASSERT_SAME(a_hold_when_full, i_clk, i_rst_n, r_s1_valid && r_out_valid && !m_axis_tready, !s_axis_tready, "command accepted while pipeline is blocked")
    `FPCD_ASSERT_NEXT(a_no_phantom_result, i_clk, i_rst_n, !r_s1_valid && !r_out_valid, !r_out_valid, "result appeared without a command")
    `FPCD_ASSERT_NEXT(a_dot_only_on_read, i_clk, i_rst_n, w_s1_adv && (r_s1_op != OP_READ), !r_out_dot, "dot reported for a command other than read dot")
    `FPCD_ASSERT_SAME(a_single_bitmap_write, i_clk, i_rst_n, w_staged_wr, !w_shown_wr, "both bitmaps written by one command")

endmodule
